@@ rtl/etr_pkg.sv @@
// Shared constants, types and the arctangent step table for the turn rate unit.
`default_nettype none

package etr_pkg;

  // Request kinds
  localparam logic [1:0] REQ_RATES = 2'd0;
  localparam logic [1:0] REQ_PITCH = 2'd1;
  localparam logic [1:0] REQ_ROLL  = 2'd2;

  // Fresh mark bits: body rates, pitch, roll
  localparam logic [2:0] MARK_RATES = 3'b001;
  localparam logic [2:0] MARK_PITCH = 3'b010;
  localparam logic [2:0] MARK_ROLL  = 3'b100;
  localparam logic [2:0] MARKS_ALL  = 3'b111;

  // Angles in 1/128 degree
  localparam int ANGLE_W = 16;
  localparam int WRAP_W  = ANGLE_W + 1;
  localparam logic signed [WRAP_W-1:0] DEG360 = 17'sd46080;
  localparam logic signed [WRAP_W-1:0] DEG180 = 17'sd23040;
  localparam logic signed [WRAP_W-1:0] DEG90  = 17'sd11520;

  // Rotator: Q24 vectors, 2^-16 degree residual angle
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int XY_W         = 27;
  localparam int Z_W          = 26;
  localparam int Z_SHIFT      = 9;
  localparam int TRIG_W       = 18;
  localparam int RND_SHIFT    = 8;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 27'sd10188014;
  localparam logic signed [XY_W-1:0] RND_HALF    = 27'sd128;

  // Datapath widths
  localparam int RATE_W     = 16;
  localparam int NUM_W      = 36;
  localparam int MAG_W      = 34;
  localparam int MUL_SPLIT  = 17;
  localparam int MUL_A_W    = MUL_SPLIT + 1;
  localparam int R2D_W      = 22;
  localparam int MUL_B_W    = R2D_W + 1;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int PART_W     = 56;
  localparam int BIAS_SHIFT = 21;
  localparam int FRAC_SHIFT = 22;
  localparam int DIVD_W     = PART_W - FRAC_SHIFT;
  localparam int DVS_W      = 17;
  localparam int QUO_W      = 24;
  localparam int CNT_W      = $clog2(QUO_W);
  localparam int OUT_W      = 24;
  localparam int FLOOR_W    = 16;

  // radians to degrees, Q16
  localparam logic [R2D_W-1:0] R2D_Q16 = 22'd3754936;

  // Output limits
  localparam logic signed [OUT_W-1:0] OUT_MAX_POS = 24'sh7FFFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN_NEG = 24'sh800000;
  localparam logic [QUO_W-1:0]        OUT_MAX_MAG = 24'h7FFFFF;
  localparam logic [QUO_W-1:0]        OUT_MIN_MAG = 24'h800000;
  localparam logic [FLOOR_W-1:0]      COS_FLOOR_RST = 16'd64;

  // Rotator results back to the sequencer
  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } cordic_res_t;

  // Divider results back to the sequencer
  typedef struct packed {
    logic             done;
    logic             overflow;
    logic [QUO_W-1:0] quotient;
  } div_res_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic signed [Z_W-1:0] atan_step(input logic [STEP_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    unique case (idx)
      4'd0:  v = 26'sd2949120;
      4'd1:  v = 26'sd1740967;
      4'd2:  v = 26'sd919879;
      4'd3:  v = 26'sd466945;
      4'd4:  v = 26'sd234378;
      4'd5:  v = 26'sd117304;
      4'd6:  v = 26'sd58666;
      4'd7:  v = 26'sd29335;
      4'd8:  v = 26'sd14668;
      4'd9:  v = 26'sd7334;
      4'd10: v = 26'sd3667;
      4'd11: v = 26'sd1833;
      4'd12: v = 26'sd917;
      4'd13: v = 26'sd458;
      4'd14: v = 26'sd229;
      4'd15: v = 26'sd115;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/euler_turn_rate_unit.sv @@
// Top level: attitude and rate store, sequencer, shared multiplier and result register.
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_ready    req_type, rate_q, rate_r, angle_deg
//   out      out  out_valid / out_ready  turn_rate, saturated
//   cfg      in   cfg_valid / cfg_ready  cfg_data (cos_floor)
//
// A request that does not complete the set of rates, pitch and roll keeps in_ready high.
// The completing request holds in_ready low through two passes of the shared CORDIC
// rotator, seven multiply, add and check steps, the divider and the load of the
// output register; a clipping cosine floor skips the last three steps and the divider.
// A result still waiting in the output register stretches the last step until taken.
// Synchronous reset clears the stored values, fresh marks and cos_floor (to 64).
`default_nettype none

module euler_turn_rate_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic signed [15:0] rate_q,
  input  logic signed [15:0] rate_r,
  input  logic signed [15:0] angle_deg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] turn_rate,
  output logic               saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  import etr_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_ROLL_GO   = 14'b00000000000010,
    S_ROLL_RUN  = 14'b00000000000100,
    S_PITCH_GO  = 14'b00000000001000,
    S_PITCH_RUN = 14'b00000000010000,
    S_MUL_Q     = 14'b00000000100000,
    S_MUL_R     = 14'b00000001000000,
    S_SUM       = 14'b00000010000000,
    S_CHECK     = 14'b00000100000000,
    S_MUL_LO    = 14'b00001000000000,
    S_MUL_HI    = 14'b00010000000000,
    S_NORM      = 14'b00100000000000,
    S_DIV_RUN   = 14'b01000000000000,
    S_OUT       = 14'b10000000000000
  } state_t;

  state_t state;
  state_t state_next;

  // stored sensor values and configuration
  logic signed [RATE_W-1:0]  stored_q;
  logic signed [RATE_W-1:0]  stored_r;
  logic signed [ANGLE_W-1:0] pitch_angle;
  logic signed [ANGLE_W-1:0] roll_angle;
  logic [2:0]                marks;
  logic [FLOOR_W-1:0]        cos_floor;

  logic       in_fire;
  logic [2:0] mark_bit;
  logic [2:0] marks_merged;
  logic       all_fresh;

  // datapath
  logic signed [TRIG_W-1:0]  sr;
  logic signed [TRIG_W-1:0]  cr;
  logic [DVS_W-1:0]          cp_mag;
  logic                      cp_neg;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [NUM_W-1:0]   num;
  logic [MAG_W-1:0]          mag;
  logic                      res_neg;
  logic [PART_W-1:0]         part;
  logic [PART_W-1:0]         nsum;
  logic                      floor_hit;
  logic signed [OUT_W-1:0]   res;
  logic                      res_sat;
  logic                      out_load;

  // shared units
  logic                      cordic_start;
  logic signed [ANGLE_W-1:0] cordic_angle;
  cordic_res_t               cordic_res;
  logic                      div_start;
  div_res_t                  div_res;

  etr_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .angle (cordic_angle),
    .res   (cordic_res)
  );

  etr_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (nsum[PART_W-1:FRAC_SHIFT]),
    .divisor  (cp_mag),
    .res      (div_res)
  );

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);

  // fresh mark for the incoming request
  always_comb begin
    unique case (req_type)
      REQ_RATES: mark_bit = MARK_RATES;
      REQ_PITCH: mark_bit = MARK_PITCH;
      REQ_ROLL:  mark_bit = MARK_ROLL;
      default:   mark_bit = '0;
    endcase
    marks_merged = marks | mark_bit;
    all_fresh    = (marks_merged == MARKS_ALL);
  end

  // rotator and divider launch
  assign cordic_start = (state == S_ROLL_GO) || (state == S_PITCH_GO);
  assign cordic_angle = (state == S_PITCH_GO) ? pitch_angle : roll_angle;
  assign div_start    = (state == S_NORM);

  // cos floor test
  assign floor_hit = (cp_mag == '0) || (cp_mag < DVS_W'(cos_floor));

  // align the high partial product and add to low part plus rounding bias
  assign nsum = part + (PART_W'(prod) << MUL_SPLIT);

  // shared multiplier operands
  always_comb begin
    unique case (state)
      S_MUL_Q: begin
        mul_a = MUL_A_W'(stored_q);
        mul_b = MUL_B_W'(sr);
      end
      S_MUL_R: begin
        mul_a = MUL_A_W'(stored_r);
        mul_b = MUL_B_W'(cr);
      end
      S_MUL_LO: begin
        mul_a = signed'({1'b0, mag[MUL_SPLIT-1:0]});
        mul_b = signed'({1'b0, R2D_Q16});
      end
      S_MUL_HI: begin
        mul_a = signed'({1'b0, mag[MAG_W-1:MUL_SPLIT]});
        mul_b = signed'({1'b0, R2D_Q16});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_fire && all_fresh) state_next = S_ROLL_GO;
      S_ROLL_GO:   state_next = S_ROLL_RUN;
      S_ROLL_RUN:  if (cordic_res.done) state_next = S_PITCH_GO;
      S_PITCH_GO:  state_next = S_PITCH_RUN;
      S_PITCH_RUN: if (cordic_res.done) state_next = S_MUL_Q;
      S_MUL_Q:     state_next = S_MUL_R;
      S_MUL_R:     state_next = S_SUM;
      S_SUM:       state_next = S_CHECK;
      S_CHECK:     state_next = floor_hit ? S_OUT : S_MUL_LO;
      S_MUL_LO:    state_next = S_MUL_HI;
      S_MUL_HI:    state_next = S_NORM;
      S_NORM:      state_next = S_DIV_RUN;
      S_DIV_RUN:   if (div_res.done) state_next = S_OUT;
      S_OUT:       if (out_load) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // control and stored state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      marks       <= '0;
      stored_q    <= '0;
      stored_r    <= '0;
      pitch_angle <= '0;
      roll_angle  <= '0;
      cos_floor   <= COS_FLOOR_RST;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        cos_floor <= cfg_data;
      end
      if (in_fire) begin
        unique case (req_type)
          REQ_RATES: begin
            stored_q <= rate_q;
            stored_r <= rate_r;
          end
          REQ_PITCH: pitch_angle <= angle_deg;
          REQ_ROLL:  roll_angle  <= angle_deg;
          default: ;
        endcase
        marks <= all_fresh ? '0 : marks_merged;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      S_ROLL_RUN: begin
        if (cordic_res.done) begin
          sr <= cordic_res.sin_v;
          cr <= cordic_res.cos_v;
        end
      end
      S_PITCH_RUN: begin
        if (cordic_res.done) begin
          cp_neg <= cordic_res.cos_v[TRIG_W-1];
          cp_mag <= cordic_res.cos_v[TRIG_W-1] ? DVS_W'(-cordic_res.cos_v)
                                               : DVS_W'(cordic_res.cos_v);
        end
      end
      S_MUL_R: num <= NUM_W'(prod);
      S_SUM:   num <= num + NUM_W'(prod);
      S_CHECK: begin
        mag     <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
        res_neg <= num[NUM_W-1] ^ cp_neg;
        if (floor_hit) begin
          res_sat <= 1'b1;
          if (num == '0) begin
            res <= '0;
          end else if (num[NUM_W-1] ^ cp_neg) begin
            res <= OUT_MIN_NEG;
          end else begin
            res <= OUT_MAX_POS;
          end
        end
      end
      S_MUL_HI: part <= PART_W'(prod) + (PART_W'(cp_mag) << BIAS_SHIFT);
      S_DIV_RUN: begin
        if (div_res.done) begin
          if (res_neg) begin
            if (div_res.overflow || div_res.quotient > OUT_MIN_MAG) begin
              res     <= OUT_MIN_NEG;
              res_sat <= 1'b1;
            end else begin
              res     <= OUT_W'(-$signed({1'b0, div_res.quotient}));
              res_sat <= 1'b0;
            end
          end else begin
            if (div_res.overflow || div_res.quotient > OUT_MAX_MAG) begin
              res     <= OUT_MAX_POS;
              res_sat <= 1'b1;
            end else begin
              res     <= signed'(div_res.quotient);
              res_sat <= 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    if (out_load) begin
      turn_rate <= res;
      saturated <= res_sat;
    end
  end

`ifndef NO_ASSERTIONS
  // a run always starts with the fresh marks cleared
  a_marks_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROLL_GO) |-> (marks == '0))
    else $error("fresh marks not cleared at start of run");

  // rotator finishes only while the sequencer waits for it
  a_cordic_done: assert property (@(posedge clk) disable iff (rst)
    cordic_res.done |-> (state == S_ROLL_RUN || state == S_PITCH_RUN))
    else $error("rotator done outside a wait state");

  // divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == S_DIV_RUN))
    else $error("divider done outside its wait state");

  // the unit only goes busy on an accepted request
  a_busy_on_req: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid))
    else $error("in_ready dropped without a request");
`endif

endmodule

`default_nettype wire

@@ rtl/etr_cordic.sv @@
// Iterative rotation-mode CORDIC: sine and cosine of an angle, one step per cycle.
`default_nettype none

module etr_cordic (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [etr_pkg::ANGLE_W-1:0]   angle,
  output etr_pkg::cordic_res_t                 res
);
  import etr_pkg::*;

  logic signed [WRAP_W-1:0] ang_ext;
  logic signed [WRAP_W-1:0] wrapped;
  logic signed [WRAP_W-1:0] folded;
  logic                     fold_neg;
  logic signed [Z_W-1:0]    z_init;

  logic signed [XY_W-1:0]   x;
  logic signed [XY_W-1:0]   y;
  logic signed [Z_W-1:0]    z;
  logic signed [XY_W-1:0]   x_next;
  logic signed [XY_W-1:0]   y_next;
  logic signed [Z_W-1:0]    z_next;
  logic signed [XY_W-1:0]   dx;
  logic signed [XY_W-1:0]   dy;
  logic signed [Z_W-1:0]    atan_v;
  logic [STEP_W-1:0]        step;
  logic                     busy;
  logic                     done;
  logic                     neg;

  logic signed [XY_W-1:0]   x_rnd;
  logic signed [XY_W-1:0]   y_rnd;
  logic signed [TRIG_W-1:0] x_q;
  logic signed [TRIG_W-1:0] y_q;

  // wrap into [-180, 180), then fold into [-90, 90] with a sign flip
  always_comb begin
    ang_ext = WRAP_W'(angle);
    priority if (ang_ext >= DEG180) begin
      wrapped = ang_ext - DEG360;
    end else if (ang_ext < -DEG180) begin
      wrapped = ang_ext + DEG360;
    end else begin
      wrapped = ang_ext;
    end
    priority if (wrapped > DEG90) begin
      folded   = wrapped - DEG180;
      fold_neg = 1'b1;
    end else if (wrapped < -DEG90) begin
      folded   = wrapped + DEG180;
      fold_neg = 1'b1;
    end else begin
      folded   = wrapped;
      fold_neg = 1'b0;
    end
    z_init = Z_W'(folded) <<< Z_SHIFT;
  end

  // one micro-rotation
  always_comb begin
    dx     = y >>> step;
    dy     = x >>> step;
    atan_v = atan_step(step);
    if (!z[Z_W-1]) begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - atan_v;
    end else begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + atan_v;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_W'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // vector and residual angle
  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_GAIN;
      y    <= '0;
      z    <= z_init;
      neg  <= fold_neg;
      step <= '0;
    end else if (busy) begin
      x    <= x_next;
      y    <= y_next;
      z    <= z_next;
      step <= step + 1'b1;
    end
  end

  // round Q24 to Q16 and undo the fold
  always_comb begin
    x_rnd = (x + RND_HALF) >>> RND_SHIFT;
    y_rnd = (y + RND_HALF) >>> RND_SHIFT;
    x_q   = TRIG_W'(x_rnd);
    y_q   = TRIG_W'(y_rnd);
  end

  assign res.done  = done;
  assign res.cos_v = neg ? -x_q : x_q;
  assign res.sin_v = neg ? -y_q : y_q;

endmodule

`default_nettype wire

@@ rtl/etr_divider.sv @@
// Restoring divider, one quotient bit per cycle, with a quotient range flag.
`default_nettype none

module etr_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [etr_pkg::DIVD_W-1:0]      dividend,
  input  logic [etr_pkg::DVS_W-1:0]       divisor,
  output etr_pkg::div_res_t               res
);
  import etr_pkg::*;

  logic [DIVD_W-QUO_W-1:0] head;
  logic [DVS_W-1:0]        dvs;
  logic [DVS_W-1:0]        rem;
  logic [DVS_W:0]          trial;
  logic [DVS_W:0]          diff;
  logic                    take;
  logic [QUO_W-1:0]        quo;
  logic [CNT_W-1:0]        cnt;
  logic                    busy;
  logic                    done;
  logic                    ovf;

  // bits above the quotient field decide overflow up front
  assign head  = dividend[DIVD_W-1:QUO_W];
  assign trial = {rem, quo[QUO_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign take  = trial >= {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(QUO_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DVS_W'(head);
      quo <= dividend[QUO_W-1:0];
      dvs <= divisor;
      ovf <= DVS_W'(head) >= divisor;
      cnt <= '0;
    end else if (busy) begin
      rem <= take ? DVS_W'(diff) : DVS_W'(trial);
      quo <= {quo[QUO_W-2:0], take};
      cnt <= cnt + 1'b1;
    end
  end

  assign res.done     = done;
  assign res.overflow = ovf;
  assign res.quotient = quo;

endmodule

`default_nettype wire

@@ tb/tb_euler_turn_rate_unit.sv @@
// Self-checking testbench for the heading turn rate unit: directed and random requests.
`default_nettype none

module tb_euler_turn_rate_unit;
  import etr_pkg::*;

  // Request code with no meaning to the block
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 120;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_UPDATES = 160;
  localparam int REPORT_LIMIT  = 10;

  // Angle units for the predictor, 1/128 degree
  localparam int ANG_FULL    = 46080;
  localparam int ANG_HALF    = 23040;
  localparam int ANG_QUARTER = 11520;

  typedef struct {
    logic [23:0] rate;
    logic        sat;
  } turn_entry_t;

  // Predicts turn rate results and checks what the block returns
  class turn_rate_tracker;
    logic [15:0] q_reg, r_reg, pitch_reg, roll_reg;
    logic [2:0]  marks;
    logic [15:0] floor_reg;
    longint      atan_tab[16];
    turn_entry_t expected_turns[$];
    int          updates, ignored, results, saturations, mismatches;

    function new();
      atan_tab = '{2949120, 1740967, 919879, 466945, 234378, 117304, 58666, 29335,
                   14668, 7334, 3667, 1833, 917, 458, 229, 115};
      q_reg = '0;
      r_reg = '0;
      pitch_reg = '0;
      roll_reg = '0;
      marks = '0;
      floor_reg = COS_FLOOR_RST;
      updates = 0;
      ignored = 0;
      results = 0;
      saturations = 0;
      mismatches = 0;
    endfunction

    function void set_floor(logic [15:0] v);
      floor_reg = v;
    endfunction

    function int pending();
      return expected_turns.size();
    endfunction

    // Rotator: sine and cosine in Q16 of an angle in 1/128 degree
    function void trig_q16(input int ang, output longint sn, output longint cs);
      int     m;
      bit     flip;
      longint x, y, z, dx, dy;
      m = ((ang % ANG_FULL) + ANG_FULL) % ANG_FULL;
      flip = 1'b0;
      if (m >= ANG_HALF) m -= ANG_FULL;
      if (m > ANG_QUARTER) begin
        m -= ANG_HALF;
        flip = 1'b1;
      end else if (m < -ANG_QUARTER) begin
        m += ANG_HALF;
        flip = 1'b1;
      end
      x = 10188014;
      y = 0;
      z = longint'(m) * 512;
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= atan_tab[i];
        end else begin
          x += dx;
          y -= dy;
          z += atan_tab[i];
        end
      end
      x = (x + 128) >>> 8;
      y = (y + 128) >>> 8;
      cs = flip ? -x : x;
      sn = flip ? -y : y;
    endfunction

    // (q*sin(roll) + r*cos(roll)) / cos(pitch), scaled to 1/64 deg/s and clipped
    function turn_entry_t predict_turn();
      turn_entry_t     e;
      longint          sr, cr, sp, cp, num, res;
      longint unsigned n, d, qv, cpm, numm;
      bit              neg, sat;
      trig_q16(int'($signed(roll_reg)), sr, cr);
      trig_q16(int'($signed(pitch_reg)), sp, cp);
      num = longint'($signed(q_reg)) * sr + longint'($signed(r_reg)) * cr;
      neg = (num < 0) != (cp < 0);
      cpm = (cp < 0) ? -cp : cp;
      numm = (num < 0) ? -num : num;
      sat = 1'b0;
      if (cp == 0 || cpm < floor_reg) begin
        sat = 1'b1;
        if (num == 0) res = 0;
        else res = neg ? -longint'(8388608) : longint'(8388607);
      end else begin
        n = numm * 64'd3754936;
        d = cpm << 22;
        qv = (n + d / 2) / d;
        if (neg) begin
          if (qv > 64'd8388608) begin
            qv = 64'd8388608;
            sat = 1'b1;
          end
          res = -longint'(qv);
        end else begin
          if (qv > 64'd8388607) begin
            qv = 64'd8388607;
            sat = 1'b1;
          end
          res = longint'(qv);
        end
      end
      e.rate = res[23:0];
      e.sat = sat;
      return e;
    endfunction

    // Accepted request: update stored values and marks
    function void note_request(logic [1:0] kind, logic [15:0] q, logic [15:0] r,
                               logic [15:0] ang);
      if (kind == REQ_RATES) begin
        q_reg = q;
        r_reg = r;
        marks |= MARK_RATES;
      end else if (kind == REQ_PITCH) begin
        pitch_reg = ang;
        marks |= MARK_PITCH;
      end else if (kind == REQ_ROLL) begin
        roll_reg = ang;
        marks |= MARK_ROLL;
      end else begin
        ignored++;
        return;
      end
      updates++;
      if (marks == MARKS_ALL) begin
        marks = '0;
        expected_turns.push_back(predict_turn());
      end
    endfunction

    // Accepted result: compare with the oldest prediction
    function void check_result(logic [23:0] rate, logic sat);
      turn_entry_t e;
      if (expected_turns.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: turn_rate %0d saturated %0b", $signed(rate), sat);
        return;
      end
      e = expected_turns.pop_front();
      results++;
      if (e.sat) saturations++;
      if (rate !== e.rate || sat !== e.sat) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch on result %0d: turn_rate exp %0d got %0d, saturated exp %0b got %0b",
                   results, $signed(e.rate), $signed(rate), e.sat, sat);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         req_type = REQ_RATES;
  logic signed [15:0] rate_q = '0;
  logic signed [15:0] rate_r = '0;
  logic signed [15:0] angle_deg = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [23:0] turn_rate;
  logic               saturated;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [15:0]        cfg_data = '0;

  turn_rate_tracker tracker;
  int               cycle_count = 0;
  int               stall_left = 0;
  int               floor_writes = 0;
  bit               no_stall = 1'b0;

  euler_turn_rate_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .rate_q    (rate_q),
    .rate_r    (rate_r),
    .angle_deg (angle_deg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .turn_rate (turn_rate),
    .saturated (saturated),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               tracker.pending());
      $display("euler_turn_rate_unit regression: fail");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int pick;
    if (no_stall) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [15:0] rand_angle();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom_range(0, ANG_FULL)) - ANG_HALF;
      4, 5:       v = $urandom;
      6, 7: begin
        // near straight up or down
        v = ($urandom_range(0, 1) ? ANG_QUARTER : -ANG_QUARTER)
            + int'($urandom_range(0, 400)) - 200;
      end
      8:          v = (int'($urandom_range(0, 4)) - 2) * ANG_QUARTER;
      default: begin
        v = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 15))
                                 : -32768 + int'($urandom_range(0, 15));
      end
    endcase
    return v[15:0];
  endfunction

  function automatic logic [15:0] rand_rate();
    int v;
    case ($urandom_range(0, 9))
      7: begin
        case ($urandom_range(0, 3))
          0:       v = 32767;
          1:       v = -32768;
          2:       v = 0;
          default: v = -1;
        endcase
      end
      8, 9:    v = int'($urandom_range(0, 200)) - 100;
      default: v = $urandom;
    endcase
    return v[15:0];
  endfunction

  // Drive one request and wait for it to be taken
  task automatic send_req(logic [1:0] kind, logic [15:0] q, logic [15:0] r, logic [15:0] ang);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= kind;
    rate_q    <= q;
    rate_r    <= r;
    angle_deg <= ang;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(kind, q, r, ang);
  endtask

  task automatic send_kind(logic [1:0] kind);
    send_req(kind, rand_rate(), rand_rate(), rand_angle());
  endtask

  // Wait until every result is back and the block has gone quiet
  task automatic settle_block();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_floor(logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_floor(v);
    floor_writes++;
    cfg_valid <= 1'b0;
  endtask

  // Extremes, saturation, wraparound, ignored code and repeated updates
  task automatic run_directed();
    send_req(REQ_UNUSED, 16'hFFFF, 16'h8000, 16'h7FFF);
    send_req(REQ_ROLL, 16'h0000, 16'h0000, 16'h0000);
    send_req(REQ_PITCH, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_req(REQ_RATES, 16'h7FFF, 16'h8000, 16'hFFFF);
    send_req(REQ_RATES, 16'h8000, 16'h7FFF, 16'h0000);
    send_req(REQ_ROLL, 16'h0000, 16'h0000, 16'(ANG_QUARTER));
    send_req(REQ_PITCH, 16'h0000, 16'h0000, 16'(ANG_HALF));
    // cosine at the floor: pitch straight up
    send_req(REQ_PITCH, 16'h0000, 16'h0000, 16'(ANG_QUARTER));
    send_req(REQ_ROLL, 16'h0000, 16'h0000, 16'(-ANG_HALF));
    send_req(REQ_RATES, 16'd1000, 16'hFC18, 16'h0000);
    // output overflow, both signs
    send_req(REQ_PITCH, 16'h0000, 16'h0000, 16'd11505);
    send_req(REQ_ROLL, 16'h0000, 16'h0000, 16'(ANG_QUARTER));
    send_req(REQ_RATES, 16'h7FFF, 16'h0000, 16'h0000);
    send_req(REQ_RATES, 16'h8000, 16'h0000, 16'h0000);
    send_req(REQ_PITCH, 16'h0000, 16'h0000, 16'd11505);
    send_req(REQ_ROLL, 16'h0000, 16'h0000, 16'(ANG_QUARTER));
    // zero numerator with cosine under the floor
    send_req(REQ_RATES, 16'h0000, 16'h0000, 16'h0000);
    send_req(REQ_PITCH, 16'h0000, 16'h0000, 16'(-ANG_QUARTER));
    send_req(REQ_ROLL, 16'h0000, 16'h0000, 16'h0000);
    // angles past half a turn wrap around; ignored code inside a set
    send_req(REQ_PITCH, 16'h0000, 16'h0000, 16'h7FFF);
    send_req(REQ_UNUSED, 16'h1234, 16'h5678, 16'h4321);
    send_req(REQ_ROLL, 16'h0000, 16'h0000, 16'h8000);
    send_req(REQ_RATES, 16'd12345, 16'hF752, 16'h0000);
  endtask

  // Mostly complete sets in random order, the rest loose requests of any code
  task automatic run_random(int count);
    logic [1:0] order[3];
    logic [1:0] tmp;
    int         start, j;
    start = tracker.updates;
    while (tracker.updates - start < count) begin
      if ($urandom_range(0, 9) < 8) begin
        order[0] = REQ_RATES;
        order[1] = REQ_PITCH;
        order[2] = REQ_ROLL;
        for (int k = 2; k > 0; k--) begin
          j = $urandom_range(0, k);
          tmp = order[k];
          order[k] = order[j];
          order[j] = tmp;
        end
        for (int k = 0; k < 3; k++) begin
          send_kind(order[k]);
          if (k == 0 && $urandom_range(0, 6) == 0) send_kind(order[0]);
          if ($urandom_range(0, 19) == 0) send_kind(REQ_UNUSED);
        end
      end else begin
        send_kind(2'($urandom_range(0, 3)));
      end
    end
  endtask

  // Result side: check, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_result(turn_rate, saturated);
    if (no_stall) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Main sequence
  initial begin
    logic [15:0] floors[RANDOM_PHASES];
    int          errors;
    tracker = new();
    floors[0] = 16'd0;
    floors[1] = 16'hFFFF;
    floors[2] = 16'($urandom);
    floors[3] = 16'($urandom_range(1, 1000));
    floors[4] = COS_FLOOR_RST;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle_block();
      write_floor(floors[p]);
      no_stall = (p == 2);
      run_random(PHASE_UPDATES);
    end
    no_stall = 1'b0;
    settle_block();

    errors = tracker.mismatches + tracker.pending();
    $display("covered %0d updates and %0d ignored requests, %0d turn rate results checked",
             tracker.updates, tracker.ignored, tracker.results);
    $display("%0d results saturated, %0d cosine floor settings, %0d mismatches",
             tracker.saturations, floor_writes, tracker.mismatches);
    if (errors == 0) begin
      $display("euler_turn_rate_unit regression: pass");
    end else begin
      $display("euler_turn_rate_unit regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/etr_pkg.sv
rtl/etr_cordic.sv
rtl/etr_divider.sv
rtl/euler_turn_rate_unit.sv
tb/tb_euler_turn_rate_unit.sv
